[design/daisy_chain_adc_frame_parser_defines.svh]
// shared assertion macros for the frame parser checks
`ifndef DAISY_CHAIN_ADC_FRAME_PARSER_DEFINES_SVH
`define DAISY_CHAIN_ADC_FRAME_PARSER_DEFINES_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define DCADC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define DCADC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/dcadc_pkg.sv]
package dcadc_pkg;

  // default chain geometry
  localparam int NUM_DEVICES_DEF         = 8;
  localparam int CHANNELS_PER_DEVICE_DEF = 8;

  // queue depths, power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 4;

  // field widths
  localparam int BYTE_W   = 8;
  localparam int DEV_W    = 3;
  localparam int SLOT_W   = 4;
  localparam int WORD_W   = 24;
  localparam int CFG_W    = 4;

  localparam logic [CFG_W-1:0] DEVICES_RESET = 4'd8;

  // byte position inside a 3-byte word
  typedef enum logic [1:0] {
    PHASE_HI  = 2'd0,
    PHASE_MID = 2'd1,
    PHASE_LO  = 2'd2
  } phase_t;

  // one classified byte, front to back
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    phase_t            phase;
    logic [SLOT_W-1:0] slot;
    logic [DEV_W-1:0]  dev;
    logic              last;
  } tag_t;

  // one finished word
  typedef struct packed {
    logic [DEV_W-1:0]         device_index;
    logic [SLOT_W-1:0]        slot;
    logic signed [WORD_W-1:0] sample;
    logic [WORD_W-1:0]        status_word;
    logic                     last_of_frame;
  } result_t;

  localparam logic [SLOT_W-1:0] STATUS_SLOT = 4'd0;

endpackage

[design/dcadc_fifo.sv]
module dcadc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = dcadc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  // depth is a power of two so the pointers wrap on their own
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[design/dcadc_front.sv]
module dcadc_front #(
  parameter int NUM_DEVICES         = dcadc_pkg::NUM_DEVICES_DEF,
  parameter int CHANNELS_PER_DEVICE = dcadc_pkg::CHANNELS_PER_DEVICE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [dcadc_pkg::BYTE_W-1:0]   data_byte,
  input  logic                           frame_start,
  input  logic                           cfg_we,
  input  logic [dcadc_pkg::CFG_W-1:0]    cfg_wdata,
  output dcadc_pkg::tag_t                tag
);

  localparam logic [dcadc_pkg::CFG_W-1:0]  NDEV_MAX  = dcadc_pkg::CFG_W'(NUM_DEVICES);
  localparam logic [dcadc_pkg::SLOT_W-1:0] LAST_SLOT =
    dcadc_pkg::SLOT_W'(CHANNELS_PER_DEVICE);

  logic [dcadc_pkg::CFG_W-1:0]  devices_r;
  dcadc_pkg::phase_t            phase_r, phase_nxt;
  logic [dcadc_pkg::SLOT_W-1:0] slot_r, slot_nxt;
  logic [dcadc_pkg::DEV_W-1:0]  dev_r, dev_nxt;

  logic [dcadc_pkg::CFG_W-1:0]  ndev;
  dcadc_pkg::phase_t            phase_cur;
  logic [dcadc_pkg::SLOT_W-1:0] slot_cur;
  logic [dcadc_pkg::DEV_W-1:0]  dev_cur;
  logic [dcadc_pkg::CFG_W-1:0]  dev_inc;
  logic                         block_end;

  // active device count, zero reads as one, clipped at the chain length
  always_comb begin
    if (devices_r == '0) begin
      ndev = dcadc_pkg::CFG_W'(1);
    end else if (devices_r > NDEV_MAX) begin
      ndev = NDEV_MAX;
    end else begin
      ndev = devices_r;
    end
  end

  // position of this byte, frame start restarts counting
  assign phase_cur = frame_start ? dcadc_pkg::PHASE_HI : phase_r;
  assign slot_cur  = frame_start ? '0 : slot_r;
  assign dev_cur   = frame_start ? '0 : dev_r;
  assign dev_inc   = {1'b0, dev_cur} + dcadc_pkg::CFG_W'(1);
  assign block_end = (slot_cur == LAST_SLOT) && (phase_cur == dcadc_pkg::PHASE_LO);

  // classified beat for the back end
  always_comb begin
    tag.data_byte = data_byte;
    tag.phase     = phase_cur;
    tag.slot      = slot_cur;
    tag.dev       = dev_cur;
    tag.last      = (slot_cur == LAST_SLOT) &&
                    ({1'b0, dev_cur} == ndev - dcadc_pkg::CFG_W'(1));
  end

  // advance byte, slot and device counters
  always_comb begin
    phase_nxt = phase_cur;
    slot_nxt  = slot_cur;
    dev_nxt   = dev_cur;
    case (phase_cur)
      dcadc_pkg::PHASE_HI:  phase_nxt = dcadc_pkg::PHASE_MID;
      dcadc_pkg::PHASE_MID: phase_nxt = dcadc_pkg::PHASE_LO;
      dcadc_pkg::PHASE_LO: begin
        phase_nxt = dcadc_pkg::PHASE_HI;
        if (block_end) begin
          slot_nxt = '0;
          dev_nxt  = (dev_inc >= ndev) ? '0 : dev_inc[dcadc_pkg::DEV_W-1:0];
        end else begin
          slot_nxt = slot_cur + dcadc_pkg::SLOT_W'(1);
        end
      end
      default: phase_nxt = dcadc_pkg::PHASE_HI;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dcadc_pkg::PHASE_HI;
      slot_r  <= '0;
      dev_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      slot_r  <= slot_nxt;
      dev_r   <= dev_nxt;
    end
  end

  // device count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      devices_r <= dcadc_pkg::DEVICES_RESET;
    end else if (cfg_we) begin
      devices_r <= cfg_wdata;
    end
  end

endmodule

[design/dcadc_back.sv]
module dcadc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tag_empty,
  input  dcadc_pkg::tag_t    tag,
  output logic               tag_pop,
  input  logic               res_pop,
  output logic               res_empty,
  output dcadc_pkg::result_t res
);

  logic [15:0]                  partial_r, partial_nxt;
  logic [dcadc_pkg::WORD_W-1:0] word;
  dcadc_pkg::result_t           res_new;
  logic                         res_push;
  logic                         res_full;
  logic [$bits(dcadc_pkg::result_t)-1:0] res_bits;

  // take a beat unless a finished word has nowhere to go
  assign tag_pop  = !tag_empty && ((tag.phase != dcadc_pkg::PHASE_LO) || !res_full);
  assign res_push = tag_pop && (tag.phase == dcadc_pkg::PHASE_LO);
  assign word     = {partial_r, tag.data_byte};

  // assemble the upper two bytes
  always_comb begin
    partial_nxt = partial_r;
    case (tag.phase)
      dcadc_pkg::PHASE_HI:  partial_nxt = {tag.data_byte, 8'h00};
      dcadc_pkg::PHASE_MID: partial_nxt = {partial_r[15:8], tag.data_byte};
      default:              partial_nxt = partial_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tag_pop) begin
      partial_r <= partial_nxt;
    end
  end

  // split the word into status or sample
  always_comb begin
    res_new.device_index  = tag.dev;
    res_new.slot          = tag.slot;
    res_new.last_of_frame = tag.last;
    if (tag.slot == dcadc_pkg::STATUS_SLOT) begin
      res_new.sample      = '0;
      res_new.status_word = word;
    end else begin
      res_new.sample      = $signed(word);
      res_new.status_word = '0;
    end
  end

  // result queue
  dcadc_fifo #(
    .WIDTH ($bits(dcadc_pkg::result_t)),
    .DEPTH (dcadc_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_new),
    .rd_en   (res_pop && !res_empty),
    .rd_data (res_bits),
    .full    (res_full),
    .empty   (res_empty)
  );

  assign res = dcadc_pkg::result_t'(res_bits);

endmodule

[design/daisy_chain_adc_frame_parser.sv]
// a word reaches the out_ ports via the byte queue, then the result queue
// throughput: one byte per cycle while full is low, one word every third byte
// the byte queue stalls only when the result queue is full and a word completes
// reset: synchronous on rst_n low; counters and queues clear, device count reads 8
module daisy_chain_adc_frame_parser #(
  parameter int NUM_DEVICES         = dcadc_pkg::NUM_DEVICES_DEF,
  parameter int CHANNELS_PER_DEVICE = dcadc_pkg::CHANNELS_PER_DEVICE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  output logic                                 full,
  input  logic [dcadc_pkg::BYTE_W-1:0]         in_data_byte,
  input  logic                                 in_frame_start,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [dcadc_pkg::DEV_W-1:0]          out_device_index,
  output logic [dcadc_pkg::SLOT_W-1:0]         out_slot,
  output logic signed [dcadc_pkg::WORD_W-1:0]  out_sample,
  output logic [dcadc_pkg::WORD_W-1:0]         out_status_word,
  output logic                                 out_last_of_frame,
  input  logic                                 cfg_we,
  input  logic [dcadc_pkg::CFG_W-1:0]          cfg_wdata
);

  logic                                 accept;
  dcadc_pkg::tag_t                      tag_in;
  logic [$bits(dcadc_pkg::tag_t)-1:0]   tag_bits;
  dcadc_pkg::tag_t                      tag_out;
  logic                                 tag_pop;
  logic                                 tag_empty;
  dcadc_pkg::result_t                   res;

  assign accept = push && !full;

  // front end: byte classification
  dcadc_front #(
    .NUM_DEVICES         (NUM_DEVICES),
    .CHANNELS_PER_DEVICE (CHANNELS_PER_DEVICE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_data_byte),
    .frame_start (in_frame_start),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .tag         (tag_in)
  );

  // classified beat queue
  dcadc_fifo #(
    .WIDTH ($bits(dcadc_pkg::tag_t)),
    .DEPTH (dcadc_pkg::QUEUE_DEPTH)
  ) u_tag_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data (tag_in),
    .rd_en   (tag_pop),
    .rd_data (tag_bits),
    .full    (full),
    .empty   (tag_empty)
  );

  assign tag_out = dcadc_pkg::tag_t'(tag_bits);

  // back end: word assembly and result queue
  dcadc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_empty (tag_empty),
    .tag       (tag_out),
    .tag_pop   (tag_pop),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  assign out_device_index  = res.device_index;
  assign out_slot          = res.slot;
  assign out_sample        = res.sample;
  assign out_status_word   = res.status_word;
  assign out_last_of_frame = res.last_of_frame;

endmodule

[design/dcadc_checker.sv]
`include "daisy_chain_adc_frame_parser_defines.svh"

module dcadc_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 empty,
  input logic                                 pop,
  input logic [dcadc_pkg::SLOT_W-1:0]         out_slot,
  input logic signed [dcadc_pkg::WORD_W-1:0]  out_sample,
  input logic [dcadc_pkg::WORD_W-1:0]         out_status_word,
  input logic                                 out_last_of_frame
);

  // status words carry no sample bits
  `DCADC_ASSERT_NOW(a_status_no_sample, !empty && (out_slot == dcadc_pkg::STATUS_SLOT), out_sample == '0, "sample set on status slot")

  // channel words carry no status bits
  `DCADC_ASSERT_NOW(a_chan_no_status, !empty && (out_slot != dcadc_pkg::STATUS_SLOT), out_status_word == '0, "status set on channel slot")

  // end of frame only on a channel slot
  `DCADC_ASSERT_NOW(a_last_on_chan, !empty && out_last_of_frame, out_slot != dcadc_pkg::STATUS_SLOT, "last_of_frame on status slot")

  // a waiting word stays until taken
  `DCADC_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_slot) && $stable(out_sample), "waiting word changed")

endmodule

bind daisy_chain_adc_frame_parser dcadc_checker u_dcadc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .empty             (empty),
  .pop               (pop),
  .out_slot          (out_slot),
  .out_sample        (out_sample),
  .out_status_word   (out_status_word),
  .out_last_of_frame (out_last_of_frame)
);
